// ----- rtl/rrrld_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Raster row run-length decoder package
// Shared constants and the run head count mask table.
// ----------------------------------------------------------------------------
package rrrld_pkg;

   // Default width limit of the run count accumulator.
   localparam int COUNT_BITS_DEFAULT = 16;

   // Configuration port geometry and register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_BITS_PER_PIXEL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_WIDTH      = 2'd1;

   // Register reset values.
   localparam logic [2:0]  BITS_PER_PIXEL_RESET = 3'd7;
   localparam logic [15:0] ROW_WIDTH_RESET      = 16'd1;

   // Mask of the count bits in a run head byte, by bits per pixel.
   function automatic logic [5:0] head_mask(input logic [2:0] bpp);
      logic [5:0] mask;
      case (bpp)
         3'd1:    mask = 6'd63;
         3'd2:    mask = 6'd31;
         3'd3:    mask = 6'd15;
         3'd4:    mask = 6'd7;
         3'd5:    mask = 6'd3;
         3'd6:    mask = 6'd1;
         default: mask = 6'd0;
      endcase
      return mask;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/raster_row_run_length_decoder_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Raster row run-length decoder
// Turns a coded raster byte stream into (pixel value, run length) pairs.
// ----------------------------------------------------------------------------
// The decoder takes one coded byte per clock unless stalled, and returns each
// run from the result register once the byte that completes it has passed the
// input register and been decoded. Every byte is decoded by the logic between
// those two registers, so a byte can follow in every cycle. A stall on the
// result side holds the input register only when the byte there would produce
// a result while the previous result still waits; bytes that produce no result
// keep moving. The user must write registers through the csr_ port only while
// no bytes are in flight (the block does not enforce this); csr_ready is always high.
module raster_row_run_length_decoder_top #(
   parameter int COUNT_BITS = rrrld_pkg::COUNT_BITS_DEFAULT
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [7:0]                        req_data_byte,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [7:0]                        rsp_pixel_value,
   output logic [15:0]                       rsp_run_length,
   output logic                              rsp_row_end,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [rrrld_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire  [rrrld_pkg::CSR_DATA_W-1:0]  csr_data
);

   // The count never exceeds the row width, so 16 bits always suffice.
   localparam int ACC_W = (COUNT_BITS < 16) ? COUNT_BITS : 16;
   localparam logic [24:0] COUNT_CAP = 25'((1 << COUNT_BITS) - 1);

   typedef enum logic [1:0] {
      PH_ROWNUM = 2'd0,
      PH_HEAD   = 2'd1,
      PH_CONT   = 2'd2
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [15:0]      pixels_ff, pixels_in;
   logic [6:0]       colour_ff, colour_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [2:0]       bpp_ff;
   logic [15:0]      row_width_ff;

   logic             s1_valid_ff;
   logic [7:0]       s1_byte_ff;

   logic             out_valid_ff;
   logic [7:0]       out_pixel_ff, out_pixel_in;
   logic [15:0]      out_length_ff, out_length_in;
   logic             out_row_end_ff, out_row_end_in;

   logic             emit;
   logic             advance;
   logic [24:0]      lim_wide;
   logic [ACC_W-1:0] lim;
   logic [15:0]      rem;
   logic [6:0]       head_colour;
   logic [ACC_W-1:0] head_count;
   logic [ACC_W-1:0] acc_clamped;
   logic [ACC_W+6:0] cont_wide;
   logic [ACC_W-1:0] cont_count;
   logic [ACC_W-1:0] run_acc;
   logic [6:0]       run_colour;
   logic             run_done;
   logic [16:0]      run_count;
   logic [15:0]      run_clamped;

   always_comb begin
      lim_wide = ({9'd0, row_width_ff} < COUNT_CAP) ? {9'd0, row_width_ff} : COUNT_CAP;
      lim      = lim_wide[ACC_W-1:0];
      rem      = (pixels_ff >= row_width_ff) ? 16'd0 : (row_width_ff - pixels_ff);

      head_colour = s1_byte_ff[6:0] >> (3'd7 - bpp_ff);
      head_count  = ACC_W'(s1_byte_ff[5:0] & rrrld_pkg::head_mask(bpp_ff));
      if (head_count > lim) begin
         head_count = lim;
      end

      // The row width may have shrunk since the accumulator was loaded.
      acc_clamped = (acc_ff > lim) ? lim : acc_ff;
      cont_wide   = {acc_clamped, s1_byte_ff[6:0]};
      cont_count  = (cont_wide > {7'd0, lim}) ? lim : cont_wide[ACC_W-1:0];

      phase_in       = phase_ff;
      pixels_in      = pixels_ff;
      colour_in      = colour_ff;
      acc_in         = acc_ff;
      run_acc        = cont_count;
      run_colour     = colour_ff;
      run_done       = 1'b0;
      emit           = 1'b0;
      out_pixel_in   = {1'b0, colour_ff} - 8'd1;
      out_length_in  = rem;
      out_row_end_in = 1'b0;

      case (phase_ff)
         PH_ROWNUM: begin
            if (!s1_byte_ff[7]) begin
               phase_in = PH_HEAD;
            end
         end
         PH_HEAD: begin
            if (s1_byte_ff == 8'd0) begin
               // End of row: pad with the last colour, then reset row state.
               emit           = 1'b1;
               out_row_end_in = 1'b1;
               phase_in       = PH_ROWNUM;
               pixels_in      = 16'd0;
               colour_in      = 7'd1;
               acc_in         = '0;
            end else begin
               colour_in  = head_colour;
               acc_in     = head_count;
               run_acc    = head_count;
               run_colour = head_colour;
               if (s1_byte_ff[7]) begin
                  phase_in = PH_CONT;
               end else begin
                  run_done = 1'b1;
               end
            end
         end
         default: begin
            acc_in = cont_count;
            if (s1_byte_ff[7]) begin
               phase_in = PH_CONT;
            end else begin
               run_done = 1'b1;
            end
         end
      endcase

      run_count   = 17'(run_acc) + 17'd1;
      run_clamped = (run_count > {1'b0, rem}) ? rem : run_count[15:0];
      if (run_done) begin
         phase_in = PH_HEAD;
         acc_in   = '0;
         if (run_clamped != 16'd0) begin
            emit          = 1'b1;
            out_pixel_in  = {1'b0, run_colour} - 8'd1;
            out_length_in = run_clamped;
            pixels_in     = pixels_ff + run_clamped;
         end
      end
   end

   // A byte leaves the input register unless its result has nowhere to go.
   assign advance   = s1_valid_ff && (!emit || !out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_ROWNUM;
         pixels_ff    <= 16'd0;
         colour_ff    <= 7'd1;
         acc_ff       <= '0;
         bpp_ff       <= rrrld_pkg::BITS_PER_PIXEL_RESET;
         row_width_ff <= rrrld_pkg::ROW_WIDTH_RESET;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rrrld_pkg::CSR_BITS_PER_PIXEL: bpp_ff       <= csr_data[2:0];
               rrrld_pkg::CSR_ROW_WIDTH:      row_width_ff <= csr_data;
               default: ;
            endcase
         end
         if (advance) begin
            phase_ff  <= phase_in;
            pixels_ff <= pixels_in;
            colour_ff <= colour_in;
            acc_ff    <= acc_in;
         end
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (advance && emit) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (!req_stall && req_valid) begin
         s1_byte_ff <= req_data_byte;
      end
      if (advance && emit) begin
         out_pixel_ff   <= out_pixel_in;
         out_length_ff  <= out_length_in;
         out_row_end_ff <= out_row_end_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_value = out_pixel_ff;
   assign rsp_run_length  = out_length_ff;
   assign rsp_row_end     = out_row_end_ff;

   // Only the row end padding run may carry a zero length.
   a_zero_only_on_row_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_run_length == 16'd0) |-> rsp_row_end)
      else $error("zero-length run without row end");

   // A row end transfer returns the decoder to the row number phase.
   a_row_end_phase: assert property (@(posedge clock) disable iff (reset)
      (advance && emit && out_row_end_in) |=> (phase_ff == PH_ROWNUM))
      else $error("row end did not restart the row number phase");

   // A result taken into the output register is never dropped while stalled.
   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> out_valid_ff)
      else $error("stalled result lost");

endmodule
`default_nettype wire
